// File: design/lfy_pkg.sv
// Shared constants, types and controller/datapath interface structs for the deal shuffle.
package lfy_pkg;

    localparam int DECK_SIZE_DEF = 52;

    localparam int SEED_W    = 31;
    localparam int GEN_W     = 32;
    localparam int DRAW_LSB  = 16;
    localparam int DRAW_W    = 15;
    localparam int RCP_SHIFT = 16;
    localparam int CARD_W    = 6;
    localparam int POS_W     = 6;
    localparam int RANK_W    = 4;
    localparam int SUIT_W    = 2;

    localparam logic [GEN_W-1:0] LCG_MUL = 32'd214013;
    localparam logic [GEN_W-1:0] LCG_ADD = 32'd2531011;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LCG,
        ST_DIV_MUL,
        ST_DIV_SUB,
        ST_DIV_FIX,
        ST_CAP_TOP,
        ST_WR_TOP,
        ST_WR_PICK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } t_state;

    typedef struct packed {
        logic load_seed;
        logic lcg_step;
        logic div_mul;
        logic div_sub;
        logic div_fix;
        logic rd_top;
        logic cap_top;
        logic rd_pick;
        logic wr_top;
        logic wr_pick;
        logic emit_rd;
        logic emit_load;
    } t_cmd;

    typedef struct packed {
        logic shuffle_last;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

// File: design/lfy_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lfy_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/lfy_ctrl.sv
// Controller state machine sequencing the shuffle steps and the card output.
module lfy_ctrl import lfy_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_seed_valid,
    output logic    o_seed_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_seed_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_seed_ready = 1'b1;
                if (i_seed_valid) begin
                    o_cmd.load_seed = 1'b1;
                    n_state         = ST_LCG;
                end
            end
            ST_LCG: begin
                o_cmd.lcg_step = 1'b1;
                n_state        = ST_DIV_MUL;
            end
            ST_DIV_MUL: begin
                o_cmd.div_mul = 1'b1;
                n_state       = ST_DIV_SUB;
            end
            ST_DIV_SUB: begin
                o_cmd.div_sub = 1'b1;
                n_state       = ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
                o_cmd.div_fix = 1'b1;
                o_cmd.rd_top  = 1'b1;
                n_state       = ST_CAP_TOP;
            end
            ST_CAP_TOP: begin
                o_cmd.cap_top = 1'b1;
                o_cmd.rd_pick = 1'b1;
                n_state       = ST_WR_TOP;
            end
            ST_WR_TOP: begin
                o_cmd.wr_top = 1'b1;
                n_state      = ST_WR_PICK;
            end
            ST_WR_PICK: begin
                o_cmd.wr_pick = 1'b1;
                if (i_status.shuffle_last) begin
                    n_state = ST_EMIT_RD;
                end else begin
                    // The generator value is no longer needed for this swap.
                    o_cmd.lcg_step = 1'b1;
                    n_state        = ST_DIV_MUL;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (i_status.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    n_state = i_status.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/lfy_datapath.sv
// Datapath: generator, reciprocal modulo unit, deck memory with valid bits, output register.
module lfy_datapath import lfy_pkg::*; #(
    parameter int DECK_SIZE = DECK_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  logic [SEED_W-1:0] i_deal_seed,
    input  logic              i_card_ready,
    output logic              o_card_valid,
    output logic [POS_W-1:0]  o_position,
    output logic [CARD_W-1:0] o_card_value,
    output logic [RANK_W-1:0] o_card_rank,
    output logic [SUIT_W-1:0] o_card_suit,
    output logic              o_last_card
);

    localparam int IW     = $clog2(DECK_SIZE);
    localparam int CW     = $clog2(DECK_SIZE + 1);
    localparam int NTAB   = 1 << CW;
    localparam int PROD_W = DRAW_W + RCP_SHIFT;
    localparam int QP_W   = DRAW_W + CW;

    logic [GEN_W-1:0]  r_gen;
    logic [CW-1:0]     r_cnt;
    logic [IW-1:0]     r_pos;
    logic [PROD_W-1:0] r_prod;
    logic [CW:0]       r_rem;
    logic [IW-1:0]     r_pick;
    logic [CARD_W-1:0] r_top;
    logic [DECK_SIZE-1:0] r_valid;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_addr;

    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_pos;
    logic [CARD_W-1:0] r_out_card;
    logic              r_out_last;

    logic [RCP_SHIFT-1:0] w_recip [NTAB];
    logic [DRAW_W-1:0]    w_draw;
    logic [DRAW_W-1:0]    w_qest;
    logic [QP_W-1:0]      w_qprod;
    logic [QP_W-1:0]      w_diff;
    logic [CW:0]          w_cnt_ext;
    logic [IW-1:0]        w_top_addr;

    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [CARD_W-1:0] w_wdata;
    logic              w_re;
    logic [IW-1:0]     w_raddr;
    logic [CARD_W-1:0] w_ram_q;
    logic [CARD_W-1:0] w_rdata;

    // Reciprocal table: floor(2^16 / i), with entries 0 and 1 set as for 2. The estimate floor(draw * recip / 2^16)
    // is the true quotient or one below it, so one conditional subtract fixes it.
    for (genvar d = 0; d < NTAB; d++) begin : g_recip
        localparam int RC = (1 << RCP_SHIFT) / ((d < 2) ? 2 : d);
        assign w_recip[d] = RCP_SHIFT'(RC);
    end

    assign w_draw     = r_gen[DRAW_LSB +: DRAW_W];
    assign w_qest     = r_prod[PROD_W-1 -: DRAW_W];
    assign w_qprod    = QP_W'(w_qest) * QP_W'(r_cnt);
    assign w_diff     = QP_W'(w_draw) - w_qprod;
    assign w_cnt_ext  = (CW + 1)'(r_cnt);
    assign w_top_addr = IW'(r_cnt - CW'(1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_gen <= GEN_W'(i_deal_seed);
        end else if (i_cmd.lcg_step) begin
            r_gen <= r_gen * LCG_MUL + LCG_ADD;
        end
        if (i_cmd.div_mul) begin
            r_prod <= PROD_W'(w_draw) * PROD_W'(w_recip[r_cnt]);
        end
        if (i_cmd.div_sub) begin
            r_rem <= w_diff[CW:0];
        end
        if (i_cmd.div_fix) begin
            r_pick <= (r_rem >= w_cnt_ext) ? IW'(r_rem - w_cnt_ext) : IW'(r_rem);
        end
        if (i_cmd.cap_top) begin
            r_top <= w_rdata;
        end
        if (w_re) begin
            r_rd_addr <= w_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= CW'(DECK_SIZE);
            r_pos    <= '0;
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_cmd.load_seed) begin
                r_cnt <= CW'(DECK_SIZE);
            end else if (i_cmd.wr_pick) begin
                r_cnt <= r_cnt - CW'(1);
            end
            if (i_cmd.load_seed) begin
                r_pos <= '0;
            end else if (i_cmd.emit_load) begin
                r_pos <= r_pos + IW'(1);
            end
            // A fresh deal starts from identity order: entries not yet written
            // read back as their own address.
            if (i_cmd.load_seed) begin
                r_valid <= '0;
            end else if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            if (w_re) begin
                r_rd_vld <= r_valid[w_raddr];
            end
        end
    end

    always_comb begin
        w_we    = i_cmd.wr_top | i_cmd.wr_pick;
        w_waddr = i_cmd.wr_top ? w_top_addr : r_pick;
        w_wdata = i_cmd.wr_top ? w_rdata : r_top;
        w_re    = i_cmd.rd_top | i_cmd.rd_pick | i_cmd.emit_rd;
        if (i_cmd.rd_top) begin
            w_raddr = w_top_addr;
        end else if (i_cmd.rd_pick) begin
            w_raddr = r_pick;
        end else begin
            w_raddr = r_pos;
        end
    end

    lfy_ram #(
        .WIDTH (CARD_W),
        .DEPTH (DECK_SIZE)
    ) u_deck (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_q)
    );

    assign w_rdata = r_rd_vld ? w_ram_q : CARD_W'(r_rd_addr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_load) begin
            r_out_valid <= 1'b1;
        end else if (i_card_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_load) begin
            r_out_pos  <= POS_W'(r_pos);
            r_out_card <= w_rdata;
            r_out_last <= (r_pos == IW'(DECK_SIZE - 1));
        end
    end

    assign o_status.shuffle_last = (r_cnt == CW'(2));
    assign o_status.emit_last    = (r_pos == IW'(DECK_SIZE - 1));
    assign o_status.out_free     = !r_out_valid || i_card_ready;

    assign o_card_valid = r_out_valid;
    assign o_position   = r_out_pos;
    assign o_card_value = r_out_card;
    assign o_card_rank  = r_out_card[CARD_W-1:SUIT_W];
    assign o_card_suit  = r_out_card[SUIT_W-1:0];
    assign o_last_card  = r_out_last;

endmodule

// File: design/lcg_fisher_yates_deal_shuffle.sv
// Top level of the card deal shuffle: controller, datapath and checks.
//
// Usage: one request on the seed channel (i_seed_valid/o_seed_ready, i_deal_seed)
// produces DECK_SIZE requests on the card channel (o_card_valid/i_card_ready),
// one per deck position in ascending order, the final one with o_last_card set.
// A new seed is taken only while the block is idle, which is as soon as the last
// card has been loaded into the output register.
// Sequence: after a seed is accepted, the generator steps once; then each of the
// DECK_SIZE-1 swaps does a reciprocal multiply, remainder, fix-up, and two reads
// and two writes on the deck memory, one access per cycle, the reads overlapping
// the fix-up and the capture of the top card; then each card is read from memory
// and loaded into the output register, waiting while the receiver stalls.
// The deck memory holds no reset contents: per-entry valid bits, cleared with
// every new seed, make untouched entries read as identity order, so there is no
// clearing pass. Reset returns the controller to idle and drops o_card_valid.
// When the receiver stalls, the current card holds in the output register and
// the block waits before loading the next one; nothing is lost or repeated.
module lcg_fisher_yates_deal_shuffle import lfy_pkg::*; #(
    parameter int DECK_SIZE = DECK_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_seed_valid,
    output logic              o_seed_ready,
    input  logic [SEED_W-1:0] i_deal_seed,
    output logic              o_card_valid,
    input  logic              i_card_ready,
    output logic [POS_W-1:0]  o_position,
    output logic [CARD_W-1:0] o_card_value,
    output logic [RANK_W-1:0] o_card_rank,
    output logic [SUIT_W-1:0] o_card_suit,
    output logic              o_last_card
);

    t_cmd    w_cmd;
    t_status w_status;

    lfy_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed_valid (i_seed_valid),
        .o_seed_ready (o_seed_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    lfy_datapath #(
        .DECK_SIZE (DECK_SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_deal_seed  (i_deal_seed),
        .i_card_ready (i_card_ready),
        .o_card_valid (o_card_valid),
        .o_position   (o_position),
        .o_card_value (o_card_value),
        .o_card_rank  (o_card_rank),
        .o_card_suit  (o_card_suit),
        .o_last_card  (o_last_card)
    );

`ifndef ASSERT_OFF
    // The deck memory has one port each way and the swap schedule never reads
    // and writes in the same cycle.
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_top || w_cmd.wr_pick) |->
            !(w_cmd.rd_top || w_cmd.rd_pick || w_cmd.emit_rd))
        else $error("deck memory read and write in the same cycle");

    // A card is never loaded over one the receiver has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_load |-> (!o_card_valid || i_card_ready))
        else $error("output register overwritten while stalled");

    // A card with the last-card flag set is always at the final position.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_card_valid && o_last_card) |-> (o_position == POS_W'(DECK_SIZE - 1)))
        else $error("last card flag on wrong position");

    // Once a seed is taken, the block is busy shuffling on the next cycle.
    a_busy_after_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_seed_valid && o_seed_ready) |=> !o_seed_ready)
        else $error("seed channel ready right after a seed was taken");
`endif

endmodule
